// ----- rtl/rsa_key_derivation_unit_assert.svh -----
// assertion macros for the rsa key derivation unit
`ifndef RSA_KEY_DERIVATION_UNIT_ASSERT_SVH
`define RSA_KEY_DERIVATION_UNIT_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define RKD_ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// implication from one cycle to the next
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/rkd_pkg.sv -----
// shared types and constants for the rsa key derivation unit
package rkd_pkg;
	localparam int PRIME_BITS_DEF = 17;
	localparam int OUT_W = 33;
	localparam logic [OUT_W-1:0] EXP_START = OUT_W'(5);
	localparam logic [OUT_W-1:0] D_LIMIT = OUT_W'(999999999);

	typedef struct packed {
		logic [PRIME_BITS_DEF-1:0] prime_p;
		logic [PRIME_BITS_DEF-1:0] prime_q;
	} rkd_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] modulus;
		logic [OUT_W-1:0] totient;
		logic [OUT_W-1:0] public_exponent;
		logic [OUT_W-1:0] private_exponent;
		logic             key_found;
	} rkd_out_t;
endpackage

// ----- rtl/rkd_mul.sv -----
// bit-serial shift-and-add multiplier
module rkd_mul #(
	parameter int AW = 17,
	parameter int PW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	output logic          done,
	output logic [PW-1:0] prod
);
	import rkd_pkg::*;

	localparam int CW = $clog2(AW + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] mcand_q;
	logic [AW-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(AW - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PW'(a);
			mplier_q <= b;
		end else if (run_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

// ----- rtl/rkd_div.sv -----
// restoring divider, one quotient bit per cycle
module rkd_div #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	import rkd_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic         run_q;
	logic [W:0]   trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;
endmodule

// ----- rtl/rsa_key_derivation_unit.sv -----
// top level: rsa key derivation from two small primes
//
//  channel | signals                    | beat
//  input   | in_valid in_ready in_data  | one pair of primes
//  output  | out_valid out_ready out_data | one derived key
//
// an item's run time depends on the data: two serial multiplies,
// then per candidate exponent a euclid gcd with one serial divide per
// step, then an extended euclid inverse with a divide and a serial
// multiply per step
// the shared 34-bit restoring divider sets the pace
// reset clears the sequencer and the valid flags; no clearing pass
// a result held in the output register blocks only the next start
module rsa_key_derivation_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rkd_pkg::rkd_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rkd_pkg::rkd_out_t out_data
);
	import rkd_pkg::*;
	`include "rsa_key_derivation_unit_assert.svh"

	localparam int PRIME_BITS = PRIME_BITS_DEF;
	localparam int W = 2 * PRIME_BITS;   // full width of n and z

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_N, S_MUL_Z, S_ECHK, S_GDIV, S_GSTEP,
		S_IDIV, S_IMUL, S_IFIN, S_OUT
	} state_t;

	state_t state_q;

	logic [PRIME_BITS-1:0] p_q, q_q;
	logic [W-1:0] n_q, z_q, cand_q;
	logic [W-1:0] ga_q, gb_q;          // gcd / euclid pair
	logic [W-1:0] x0_q, x1_q;          // inverse coefficients
	logic         x0neg_q;
	logic [W-1:0] qt_q;
	logic         have_e_q;

	// arithmetic unit control
	logic mul_start, mul_done, mul_busy;
	logic div_start, div_done, div_busy;
	logic [PRIME_BITS-1:0] mul_a, mul_b;
	logic [W-1:0] mul_prod;
	logic [W-1:0] div_q, div_r;

	// the coefficient multiply qt*x1 uses its own wide multiplier instance
	logic          cm_start, cm_done;
	logic [W-1:0]  cm_prod;

	always_comb begin
		mul_a = p_q;
		mul_b = q_q;
		if (state_q == S_MUL_Z || (state_q == S_MUL_N && mul_done)) begin
			mul_a = (p_q != '0) ? p_q - 1'b1 : '0;
			mul_b = (q_q != '0) ? q_q - 1'b1 : '0;
		end
	end

	rkd_mul #(.AW(PRIME_BITS), .PW(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
	);

	rkd_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(ga_q), .divisor(gb_q), .done(div_done),
		.quot(div_q), .rem(div_r)
	);

	rkd_mul #(.AW(W), .PW(W)) u_cmul (
		.clk(clk), .arst_n(arst_n), .start(cm_start),
		.a(qt_q), .b(x1_q), .done(cm_done), .prod(cm_prod)
	);

	assign mul_busy = (state_q == S_MUL_N) || (state_q == S_MUL_Z);
	assign div_busy = (state_q == S_GDIV) || (state_q == S_IDIV);
	// a waiting key beat holds off the next pair
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	// candidate test in one place: the range check in S_ECHK, ahead of a gcd run
	logic          cand_ok;
	logic [W-1:0]  inv_fix;
	logic [W-1:0]  x0_mod;
	assign cand_ok = (cand_q < n_q);
	// x0 never exceeds z, so mod is one compare and subtract
	assign x0_mod  = (x0_q >= z_q) ? x0_q - z_q : x0_q;
	always_comb begin
		inv_fix = (x0neg_q && x0_mod != '0) ? z_q - x0_mod : x0_mod;
		if (inv_fix < W'(EXP_START))
			inv_fix = inv_fix + z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			mul_start <= 1'b0;
			div_start <= 1'b0;
			cm_start  <= 1'b0;
			have_e_q  <= 1'b0;
		end else begin
			mul_start <= 1'b0;
			div_start <= 1'b0;
			cm_start  <= 1'b0;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !out_valid) begin
						p_q       <= in_data.prime_p[PRIME_BITS-1:0];
						q_q       <= in_data.prime_q[PRIME_BITS-1:0];
						mul_start <= 1'b1;
						state_q   <= S_MUL_N;
					end
				end
				S_MUL_N: begin
					if (mul_done) begin
						n_q       <= mul_prod;
						mul_start <= 1'b1;
						state_q   <= S_MUL_Z;
					end
				end
				S_MUL_Z: begin
					if (mul_done) begin
						z_q      <= mul_prod;
						cand_q   <= W'(EXP_START);
						have_e_q <= 1'b0;
						state_q  <= S_ECHK;
					end
				end
				S_ECHK: begin
					// next candidate: loop ends when cand reaches z
					if (cand_q >= z_q) begin
						state_q <= S_OUT;
					end else if (!cand_ok) begin
						cand_q <= cand_q + 1'b1;
					end else begin
						ga_q    <= cand_q;
						gb_q    <= z_q;
						state_q <= S_GSTEP;
					end
				end
				S_GSTEP: begin
					if (gb_q == '0) begin
						if (ga_q == W'(1)) begin
							have_e_q <= 1'b1;
							ga_q     <= z_q;
							gb_q     <= cand_q;
							x0_q     <= '0;
							x1_q     <= W'(1);
							x0neg_q  <= 1'b1;
							state_q  <= S_IFIN;
						end else begin
							cand_q  <= cand_q + 1'b1;
							state_q <= S_ECHK;
						end
					end else begin
						div_start <= 1'b1;
						state_q   <= S_GDIV;
					end
				end
				S_GDIV: begin
					if (div_done) begin
						ga_q    <= gb_q;
						gb_q    <= div_r;
						state_q <= S_GSTEP;
					end
				end
				S_IFIN: begin
					if (gb_q == '0) begin
						state_q <= S_OUT;
					end else begin
						div_start <= 1'b1;
						state_q   <= S_IDIV;
					end
				end
				S_IDIV: begin
					if (div_done) begin
						qt_q     <= div_q;
						ga_q     <= gb_q;
						gb_q     <= div_r;
						cm_start <= 1'b1;
						state_q  <= S_IMUL;
					end
				end
				S_IMUL: begin
					if (cm_done) begin
						x0_q    <= x1_q;
						x1_q    <= x0_q + cm_prod;
						x0neg_q <= !x0neg_q;
						state_q <= S_IFIN;
					end
				end
				S_OUT: begin
					out_data.modulus          <= n_q[OUT_W-1:0];
					out_data.totient          <= z_q[OUT_W-1:0];
					out_data.public_exponent  <= have_e_q ? cand_q[OUT_W-1:0] : '0;
					if (have_e_q && inv_fix < W'(D_LIMIT)) begin
						out_data.private_exponent <= inv_fix[OUT_W-1:0];
						out_data.key_found        <= 1'b1;
					end else begin
						out_data.private_exponent <= '0;
						out_data.key_found        <= 1'b0;
					end
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RKD_ASSERT_ALWAYS(a_ready_idle, clk, arst_n, !(in_ready && state_q != S_IDLE))
	`RKD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`RKD_ASSERT_ALWAYS(a_one_unit, clk, arst_n, !(mul_busy && div_busy))
	`RKD_ASSERT_NEXT(a_found_e, clk, arst_n,
		state_q == S_OUT, !out_data.key_found || out_data.public_exponent != '0)
endmodule

// ----- tb/sv/tb_rsa_key_derivation_unit.sv -----
// self-checking testbench for the rsa key derivation unit
`timescale 1ns / 100ps

module tb_rsa_key_derivation_unit;
	import rkd_pkg::*;

	localparam int PW = PRIME_BITS_DEF;
	localparam longint unsigned KEY_SEARCH_END = 64'd999999999;
	localparam longint unsigned OUT_MASK = (64'd1 << OUT_W) - 1;
	localparam int N_RANDOM = 280;
	localparam longint MAX_CYCLES = 64'd20000000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	rkd_in_t   in_data;
	logic      out_valid;
	logic      out_ready;
	rkd_out_t  out_data;

	// one row of the directed table; check_lit marks rows whose key is typed in
	typedef struct {
		logic [PW-1:0] p;
		logic [PW-1:0] q;
		bit            check_lit;
		rkd_out_t      lit;
	} key_row_t;

	rkd_out_t  key_queue[$];
	int        n_errors;
	int        n_keys;
	int        n_sent;
	int        n_nokey;
	longint    cycle_count;
	bit        stim_done;

	rsa_key_derivation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
		longint unsigned r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// extended euclid with magnitude coefficients and a sign toggle
	function automatic longint unsigned inverse_mod(longint unsigned e, longint unsigned z);
		longint unsigned a, b, c0, c1, c2, qt, r;
		bit neg;
		a = z;
		b = e;
		c0 = 0;
		c1 = 1;
		neg = 1'b1;
		while (b != 0) begin
			qt = a / b;
			r = a - qt * b;
			c2 = c0 + qt * c1;
			a = b;
			b = r;
			c0 = c1;
			c1 = c2;
			neg = ~neg;
		end
		c0 = c0 % z;
		if (neg && c0 != 0)
			c0 = z - c0;
		return c0;
	endfunction

	// derive the expected key for one pair of primes
	function automatic rkd_out_t derive_key(logic [PW-1:0] p, logic [PW-1:0] q);
		longint unsigned n, z, pm, qm, e, d, cand, inv;
		bit have_e;
		rkd_out_t k;
		n = 64'(p) * 64'(q);
		pm = (p > 0) ? 64'(p) - 1 : 0;
		qm = (q > 0) ? 64'(q) - 1 : 0;
		z = pm * qm;
		e = 0;
		d = 0;
		have_e = 1'b0;
		k.key_found = 1'b0;
		for (cand = 64'(EXP_START); cand < z; cand++) begin
			if (cand < n && gcd64(cand, z) == 1) begin
				e = cand;
				have_e = 1'b1;
				break;
			end
		end
		if (have_e) begin
			inv = inverse_mod(e, z);
			if (inv < 64'(EXP_START))
				inv += z;
			if (inv < KEY_SEARCH_END) begin
				d = inv;
				k.key_found = 1'b1;
			end
		end
		k.modulus = OUT_W'(n & OUT_MASK);
		k.totient = OUT_W'(z & OUT_MASK);
		k.public_exponent = OUT_W'(e & OUT_MASK);
		k.private_exponent = OUT_W'(d & OUT_MASK);
		return k;
	endfunction

	// some primes spread over the range, the largest 65539; only the first fourteen entries are drawn
	function automatic logic [PW-1:0] pick_prime();
		logic [PW-1:0] pr[16] = '{5, 7, 11, 13, 17, 61, 53, 257, 1009, 7919,
			65521, 65537, 65539, 40009, 3, 2};
		return pr[$urandom_range(13, 0)];
	endfunction

	// send one pair of primes; valid stays up across back-to-back beats
	// otherwise valid drops and the input goes idle before the next beat
	task automatic send_pair(logic [PW-1:0] p, logic [PW-1:0] q, bit keep_valid);
		rkd_out_t k;
		in_valid <= 1'b1;
		in_data <= '{prime_p: p, prime_q: q};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		k = derive_key(p, q);
		key_queue.push_back(k);
		n_sent++;
		if (!k.key_found)
			n_nokey++;
		if (!keep_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		key_row_t rows[$];
		key_row_t rw;
		logic [PW-1:0] p, q;
		int burst, gap, i;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		n_sent = 0;
		n_nokey = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero primes: totient 0 so no exponent at all
		rw = '{p: 0, q: 0, check_lit: 1, lit: '{0, 0, 0, 0, 1'b0}};
		rows.push_back(rw);
		rw = '{p: 0, q: 17'h1ffff, check_lit: 1, lit: '{0, 0, 0, 0, 1'b0}};
		rows.push_back(rw);
		rw = '{p: 17'h1ffff, q: 0, check_lit: 1, lit: '{0, 0, 0, 0, 1'b0}};
		rows.push_back(rw);
		// p = 1: totient 0, modulus q
		rw = '{p: 1, q: 7, check_lit: 1, lit: '{7, 0, 0, 0, 1'b0}};
		rows.push_back(rw);
		// totient too small for an exponent from five
		rw = '{p: 2, q: 3, check_lit: 1, lit: '{6, 2, 0, 0, 1'b0}};
		rows.push_back(rw);
		rw = '{p: 3, q: 3, check_lit: 1, lit: '{9, 4, 0, 0, 1'b0}};
		rows.push_back(rw);
		// textbook pairs, equal inputs and a non-prime pair
		rw = '{p: 5, q: 7, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 5, q: 5, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 61, q: 53, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 4, q: 9, check_lit: 0, lit: '0};
		rows.push_back(rw);
		// largest primes in the list: the first pair has modulus and totient beyond 32 bits
		rw = '{p: 65539, q: 65539, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 65537, q: 65521, check_lit: 0, lit: '0};
		rows.push_back(rw);
		// full-scale field: products past 33 bits are reported masked
		rw = '{p: 17'h1ffff, q: 17'h1ffff, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 17'h1ffff, q: 17'h10000, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 17'h15555, q: 17'h0aaaa, check_lit: 0, lit: '0};
		rows.push_back(rw);
		rw = '{p: 17'h0aaab, q: 17'h15555, check_lit: 0, lit: '0};
		rows.push_back(rw);

		foreach (rows[r]) begin
			if (rows[r].check_lit && derive_key(rows[r].p, rows[r].q) != rows[r].lit) begin
				$display("%0t table row %0d: expected %h actual %h", $time, r,
					rows[r].lit, derive_key(rows[r].p, rows[r].q));
				n_errors++;
			end
			send_pair(rows[r].p, rows[r].q, 1'b0);
		end

		// random part in bursts; most beats are primes from the list, a few raw fields or small values
		i = 0;
		while (i < N_RANDOM) begin
			burst = $urandom_range(8, 1);
			for (int b = 0; b < burst && i < N_RANDOM; b++) begin
				case ($urandom_range(9, 0))
					0: begin
						p = 17'($urandom);
						q = 17'($urandom);
					end
					1: begin
						p = 17'($urandom_range(40, 0));
						q = 17'($urandom_range(40, 0));
					end
					default: begin
						p = pick_prime();
						q = pick_prime();
					end
				endcase
				send_pair(p, q, (b < burst - 1) && (i < N_RANDOM - 1));
				i++;
			end
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern: runs of ready of varying length, each followed by a stall half of the time
	initial begin
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(12, 1);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if ($urandom_range(1, 0)) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	// compare each key beat with the oldest expectation
	always @(posedge clk) begin
		rkd_out_t exp_key;
		if (arst_n && out_valid && out_ready) begin
			if (key_queue.size() == 0) begin
				$display("%0t unexpected key beat: actual %h", $time, out_data);
				n_errors++;
			end else begin
				exp_key = key_queue.pop_front();
				n_keys++;
				if (out_data.modulus !== exp_key.modulus) begin
					$display("%0t modulus: expected %0d actual %0d", $time,
						exp_key.modulus, out_data.modulus);
					n_errors++;
				end
				if (out_data.totient !== exp_key.totient) begin
					$display("%0t totient: expected %0d actual %0d", $time,
						exp_key.totient, out_data.totient);
					n_errors++;
				end
				if (out_data.public_exponent !== exp_key.public_exponent) begin
					$display("%0t public exponent: expected %0d actual %0d", $time,
						exp_key.public_exponent, out_data.public_exponent);
					n_errors++;
				end
				if (out_data.private_exponent !== exp_key.private_exponent) begin
					$display("%0t private exponent: expected %0d actual %0d", $time,
						exp_key.private_exponent, out_data.private_exponent);
					n_errors++;
				end
				if (out_data.key_found !== exp_key.key_found) begin
					$display("%0t key found: expected %0b actual %0b", $time,
						exp_key.key_found, out_data.key_found);
					n_errors++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		n_errors = 0;
		n_keys = 0;
		cycle_count = 0;
		fork
			begin
				wait (stim_done);
				while (key_queue.size() != 0)
					@(posedge clk);
				repeat (200) @(posedge clk);
			end
			begin
				while (cycle_count < MAX_CYCLES) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("%0t timeout with %0d keys outstanding", $time, key_queue.size());
				$display("tb_rsa_key_derivation_unit: errors");
				$finish;
			end
		join_any
		$display("%0d prime pairs sent, %0d keys checked, %0d without a key pair",
			n_sent, n_keys, n_nokey);
		if (n_errors == 0)
			$display("tb_rsa_key_derivation_unit: clean");
		else
			$display("tb_rsa_key_derivation_unit: errors");
		$finish;
	end

endmodule

// ----- rsa_key_derivation_unit.f -----
+incdir+rtl
rtl/rkd_pkg.sv
rtl/rkd_mul.sv
rtl/rkd_div.sv
rtl/rsa_key_derivation_unit.sv
tb/sv/tb_rsa_key_derivation_unit.sv
